[sv/gdu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdu_pkg
// Types, codes and calendar tables shared by the Gregorian date unit.
// ----------------------------------------------------------------------------
package gdu_pkg;

	localparam int unsigned YEAR_MAX_DEF = 9999;
	localparam int unsigned YEAR_CAP     = 16383;

	// operation codes
	localparam logic [2:0] OP_NEXT    = 3'd0;
	localparam logic [2:0] OP_PREV    = 3'd1;
	localparam logic [2:0] OP_ADD     = 3'd2;
	localparam logic [2:0] OP_SUB     = 3'd3;
	localparam logic [2:0] OP_BETWEEN = 3'd4;
	localparam logic [2:0] OP_WEEKDAY = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_ORDER   = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [21:0] day_count;
		logic [13:0] later_year;
		logic [3:0]  later_month;
		logic [4:0]  later_day;
	} gdu_req_t;

	typedef struct packed {
		logic [13:0] result_year;
		logic [3:0]  result_month;
		logic [4:0]  result_day;
		logic [21:0] days_apart;
		logic [2:0]  weekday;
		logic [1:0]  status;
	} gdu_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIVA,
		S_CHECK,
		S_DIVB,
		S_CHKB,
		S_WALK,
		S_STEP,
		S_DIVW,
		S_DIV7,
		S_DONE
	} gdu_state_t;

	typedef enum logic {
		DIV_100,
		DIV_7
	} gdu_div_t;

	typedef struct packed {
		logic load;
		logic fwd;
		logic back;
	} gdu_date_cmd_t;

	// leap from year mod 4, year mod 100 and (year / 100) mod 4
	function automatic logic leap_of(input logic [1:0] ylo, input logic [6:0] r100,
			input logic [1:0] c4);
		return (ylo == 2'd0) && ((r100 != 7'd0) || (c4 == 2'd0));
	endfunction

	// month length, 0 for a month outside 1..12
	function automatic logic [4:0] month_len(input logic lp, input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = lp ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// (13 * (m + 1)) / 5 for the shifted month 3..14
	function automatic logic [5:0] zeller_term(input logic [3:0] m);
		logic [5:0] t;
		unique case (m)
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			4'd13:   t = 6'd36;
			4'd14:   t = 6'd39;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

[sv/gdu_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdu_div
// Divider by 100 or 7 using reciprocal multiplication; the quotient is registered
// from the product, then the remainder by back-multiplying.
// ----------------------------------------------------------------------------
module gdu_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [13:0]      dividend,
	input  wire gdu_pkg::gdu_div_t divisor,
	output logic                  busy,
	output logic [7:0]            quo,
	output logic [6:0]            rem
);
	import gdu_pkg::*;

	// ceil(2^19 / 100) and ceil(2^17 / 7); exact for any 14-bit dividend
	localparam logic [14:0] RECIP_100 = 15'd5243;
	localparam logic [14:0] RECIP_7   = 15'd18725;

	logic [1:0]  phase_q;
	gdu_div_t    sel_q;
	logic [13:0] dvd_q;
	logic [11:0] quo_q;
	logic [6:0]  rem_q;
	logic [28:0] prod;
	logic [11:0] quo_nx;
	logic [13:0] back_prod;
	logic [13:0] diff;

	assign prod      = 29'(dvd_q) * 29'((sel_q == DIV_100) ? RECIP_100 : RECIP_7);
	assign quo_nx    = (sel_q == DIV_100) ? {2'b00, prod[28:19]} : prod[28:17];
	assign back_prod = 14'(quo_q) * ((sel_q == DIV_100) ? 14'd100 : 14'd7);
	assign diff      = dvd_q - back_prod;

	// phase 2: quotient from the product, phase 1: remainder by back-multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (start) begin
			phase_q <= 2'd2;
		end else if (phase_q != 2'd0) begin
			phase_q <= phase_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			sel_q <= divisor;
		end else if (phase_q == 2'd2) begin
			quo_q <= quo_nx;
		end else if (phase_q == 2'd1) begin
			rem_q <= diff[6:0];
		end
	end

	assign busy = (phase_q != 2'd0);
	assign quo  = quo_q[7:0];
	assign rem  = rem_q;

endmodule
`default_nettype wire

[sv/gdu_date.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdu_date
// Date register that steps one day forward or back per cycle, tracking the
// year residues that decide leap years.
// ----------------------------------------------------------------------------
module gdu_date #(
	parameter int unsigned YEAR_MAX = gdu_pkg::YEAR_MAX_DEF
) (
	input  wire logic                  clk,
	input  wire gdu_pkg::gdu_date_cmd_t cmd,
	input  wire logic [13:0]           load_year,
	input  wire logic [3:0]            load_month,
	input  wire logic [4:0]            load_day,
	input  wire logic [6:0]            load_r100,
	input  wire logic [1:0]            load_c4,
	output logic [13:0]                year,
	output logic [3:0]                 month,
	output logic [4:0]                 day,
	output logic                       leap,
	output logic                       at_top,
	output logic                       at_bottom
);
	import gdu_pkg::*;

	localparam logic [13:0] YEAR_LIMIT =
		(YEAR_MAX > YEAR_CAP) ? 14'(YEAR_CAP) : 14'(YEAR_MAX);

	logic [13:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [6:0]  r100_q;
	logic [1:0]  c4_q;
	logic [4:0]  len_cur;
	logic [4:0]  len_prev;

	assign leap     = leap_of(year_q[1:0], r100_q, c4_q);
	assign len_cur  = month_len(leap, month_q);
	assign len_prev = month_len(leap, month_q - 4'd1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q  <= load_year;
			month_q <= load_month;
			day_q   <= load_day;
			r100_q  <= load_r100;
			c4_q    <= load_c4;
		end else if (cmd.fwd) begin
			if (day_q < len_cur) begin
				day_q <= day_q + 5'd1;
			end else begin
				day_q <= 5'd1;
				if (month_q == 4'd12) begin
					month_q <= 4'd1;
					year_q  <= year_q + 14'd1;
					if (r100_q == 7'd99) begin
						r100_q <= 7'd0;
						c4_q   <= c4_q + 2'd1;
					end else begin
						r100_q <= r100_q + 7'd1;
					end
				end else begin
					month_q <= month_q + 4'd1;
				end
			end
		end else if (cmd.back) begin
			if (day_q > 5'd1) begin
				day_q <= day_q - 5'd1;
			end else if (month_q == 4'd1) begin
				month_q <= 4'd12;
				day_q   <= 5'd31;
				year_q  <= year_q - 14'd1;
				if (r100_q == 7'd0) begin
					r100_q <= 7'd99;
					c4_q   <= c4_q - 2'd1;
				end else begin
					r100_q <= r100_q - 7'd1;
				end
			end else begin
				month_q <= month_q - 4'd1;
				day_q   <= len_prev;
			end
		end
	end

	assign at_top    = (year_q == YEAR_LIMIT) && (month_q == 4'd12) && (day_q == 5'd31);
	assign at_bottom = (year_q == 14'd1) && (month_q == 4'd1) && (day_q == 5'd1);
	assign year      = year_q;
	assign month     = month_q;
	assign day       = day_q;

endmodule
`default_nettype wire

[sv/gregorian_date_unit_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a divider run on the year, a date check, then stepping for next/previous
//   and add/subtract, a walk for days between, or two divider runs for weekday.
// Throughput: one beat in flight; the next beat is taken the cycle after the result
//   is registered. The day stepper moves one day per cycle.
// Reset: arst_n clears the sequencer and the output valid asynchronously.
// ----------------------------------------------------------------------------
// gregorian_date_unit_core
// Gregorian date arithmetic: step, add/subtract days, distance and weekday.
// ----------------------------------------------------------------------------
module gregorian_date_unit_core #(
	parameter int unsigned YEAR_MAX = gdu_pkg::YEAR_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire gdu_pkg::gdu_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output gdu_pkg::gdu_rsp_t      rsp
);
	import gdu_pkg::*;

	localparam logic [13:0] YEAR_LIMIT =
		(YEAR_MAX > YEAR_CAP) ? 14'(YEAR_CAP) : 14'(YEAR_MAX);

	gdu_state_t    state_q, state_nx;
	gdu_req_t      in_q;
	gdu_rsp_t      out_q;
	logic          out_valid_q;
	logic [21:0]   cnt_q;
	logic [21:0]   apart_q;
	logic [2:0]    wd_q;
	logic [1:0]    st_q;
	logic          use_date_q;

	logic          div_start;
	gdu_div_t      div_sel;
	logic [13:0]   div_dividend;
	logic          div_busy;
	logic [7:0]    div_quo;
	logic [6:0]    div_rem;

	gdu_date_cmd_t date_cmd;
	logic [13:0]   cur_year;
	logic [3:0]    cur_month;
	logic [4:0]    cur_day;
	logic          cur_leap;
	logic          at_top;
	logic          at_bottom;

	logic          accept;
	logic          out_free;
	logic          valid_a;
	logic          valid_b;
	logic [4:0]    len_a;
	logic [4:0]    len_b;
	logic          a_after_b;
	logic          at_target;
	logic          fwd_op;
	logic          blocked;
	logic [13:0]   zyear;
	logic [3:0]    zmonth;
	logic [10:0]   h_sum;

	assign accept   = req_valid && !req_stall;
	assign out_free = !out_valid_q || !rsp_stall;

	// first date, as held by the stepper after load
	assign len_a   = month_len(cur_leap, cur_month);
	assign valid_a = (cur_year != 14'd0) && (cur_year <= YEAR_LIMIT) &&
		(cur_day != 5'd0) && (cur_day <= len_a);

	// later date, leap from the divider run on its year
	assign len_b   = month_len(leap_of(in_q.later_year[1:0], div_rem, div_quo[1:0]),
		in_q.later_month);
	assign valid_b = (in_q.later_year != 14'd0) && (in_q.later_year <= YEAR_LIMIT) &&
		(in_q.later_day != 5'd0) && (in_q.later_day <= len_b);

	assign a_after_b = {in_q.year, in_q.month, in_q.day} >
		{in_q.later_year, in_q.later_month, in_q.later_day};
	assign at_target = {cur_year, cur_month, cur_day} ==
		{in_q.later_year, in_q.later_month, in_q.later_day};

	assign fwd_op  = (in_q.operation == OP_NEXT) || (in_q.operation == OP_ADD);
	assign blocked = fwd_op ? at_top : at_bottom;

	// Zeller: January and February count as months 13 and 14 of the prior year;
	// the extra 6 moves Zeller's Saturday-based count to 0 = Sunday
	assign zyear  = (in_q.month < 4'd3) ? in_q.year - 14'd1 : in_q.year;
	assign zmonth = (in_q.month < 4'd3) ? in_q.month + 4'd12 : in_q.month;
	assign h_sum  = 11'(in_q.day) + 11'(zeller_term(zmonth)) + 11'(div_rem) +
		11'(div_rem >> 2) + 11'(div_quo >> 2) + (11'(div_quo) << 2) + 11'(div_quo) +
		11'd6;

	gdu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_sel),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	gdu_date #(
		.YEAR_MAX (YEAR_MAX)
	) u_date (
		.clk        (clk),
		.cmd        (date_cmd),
		.load_year  (in_q.year),
		.load_month (in_q.month),
		.load_day   (in_q.day),
		.load_r100  (div_rem),
		.load_c4    (div_quo[1:0]),
		.year       (cur_year),
		.month      (cur_month),
		.day        (cur_day),
		.leap       (cur_leap),
		.at_top     (at_top),
		.at_bottom  (at_bottom)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (req_valid) state_nx = S_DIVA;
			S_DIVA:  if (!div_busy) state_nx = S_CHECK;
			S_CHECK: begin
				priority if (in_q.operation > OP_WEEKDAY) state_nx = S_DONE;
				else if (!valid_a)                        state_nx = S_DONE;
				else if (in_q.operation <= OP_PREV)       state_nx = S_STEP;
				else if (in_q.operation <= OP_SUB)
					state_nx = (in_q.day_count == 22'd0) ? S_DONE : S_STEP;
				else if (in_q.operation == OP_BETWEEN)    state_nx = S_DIVB;
				else                                      state_nx = S_DIVW;
			end
			S_DIVB:  if (!div_busy) state_nx = S_CHKB;
			S_CHKB:  state_nx = (!valid_b || a_after_b) ? S_DONE : S_WALK;
			S_WALK:  if (at_target) state_nx = S_DONE;
			S_STEP:  if (blocked || cnt_q == 22'd1) state_nx = S_DONE;
			S_DIVW:  if (!div_busy) state_nx = S_DIV7;
			S_DIV7:  if (!div_busy) state_nx = S_DONE;
			S_DONE:  if (out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		div_start     = 1'b0;
		div_sel       = DIV_100;
		div_dividend  = req.year;
		date_cmd      = '0;
		req_stall     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				div_start = req_valid;
			end
			S_DIVA: date_cmd.load = !div_busy;
			S_CHECK: begin
				div_start    = valid_a && ((in_q.operation == OP_BETWEEN) ||
					(in_q.operation == OP_WEEKDAY));
				div_dividend = (in_q.operation == OP_BETWEEN) ? in_q.later_year : zyear;
			end
			S_WALK: date_cmd.fwd = !at_target;
			S_STEP: begin
				date_cmd.fwd  = !blocked && fwd_op;
				date_cmd.back = !blocked && !fwd_op;
			end
			S_DIVW: begin
				div_start    = !div_busy;
				div_sel      = DIV_7;
				div_dividend = 14'(h_sum);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				in_q       <= req;
				st_q       <= ST_OK;
				apart_q    <= 22'd0;
				wd_q       <= 3'd0;
				use_date_q <= 1'b0;
			end
			S_CHECK: begin
				if (in_q.operation <= OP_WEEKDAY && !valid_a) begin
					st_q <= ST_INVALID;
				end else if (in_q.operation <= OP_SUB) begin
					use_date_q <= 1'b1;
					cnt_q      <= (in_q.operation <= OP_PREV) ? 22'd1 : in_q.day_count;
				end
			end
			S_CHKB: begin
				if (!valid_b) begin
					st_q <= ST_INVALID;
				end else if (a_after_b) begin
					st_q <= ST_ORDER;
				end
			end
			S_WALK: if (!at_target && apart_q != '1) apart_q <= apart_q + 22'd1;
			S_STEP: begin
				if (blocked) begin
					st_q       <= ST_RANGE;
					use_date_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 22'd1;
				end
			end
			S_DIV7: if (!div_busy) wd_q <= div_rem[2:0];
			S_DONE: if (out_free) begin
				out_q.result_year  <= use_date_q ? cur_year : in_q.year;
				out_q.result_month <= use_date_q ? cur_month : in_q.month;
				out_q.result_day   <= use_date_q ? cur_day : in_q.day;
				out_q.days_apart   <= apart_q;
				out_q.weekday      <= wd_q;
				out_q.status       <= st_q;
			end
			default: ;
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives date beats into gregorian_date_unit_core and checks every result
// against a calendar predictor built on day serials counted from 0001-01-01.
// ----------------------------------------------------------------------------
module testbench;
	import gdu_pkg::*;

	localparam int unsigned YEAR_LIMIT     = (YEAR_MAX_DEF > YEAR_CAP) ? YEAR_CAP : YEAR_MAX_DEF;
	localparam int unsigned ITEM_TOTAL     = 700;
	localparam int unsigned RESET_CYCLES   = 12;
	localparam int unsigned HOLD_AT        = 250;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned DRAIN_AT       = 480;
	localparam int unsigned TAIL_CYCLES    = 64;
	localparam int unsigned WATCHDOG_LIMIT = 200000;
	localparam int unsigned COUNT_ONES     = (1 << 22) - 1;

	// codes the block leaves unused; they must echo the date
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	class calendar_scoreboard;
		localparam int unsigned APART_MAX = (1 << 22) - 1;

		gdu_rsp_t    expected_rsp[$];
		int unsigned year_limit;
		int unsigned failures;
		int unsigned results_seen;

		function new(int unsigned limit);
			year_limit   = limit;
			failures     = 0;
			results_seen = 0;
		endfunction

		function bit is_leap(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function int unsigned days_in_month(bit lp, int unsigned m);
			case (m)
				2:           return lp ? 29 : 28;
				4, 6, 9, 11: return 30;
				default:     return 31;
			endcase
		endfunction

		function bit date_ok(int unsigned y, int unsigned m, int unsigned d);
			if (y < 1 || y > year_limit || m < 1 || m > 12 || d < 1)
				return 1'b0;
			return d <= days_in_month(is_leap(y), m);
		endfunction

		// day 0 is 0001-01-01
		function int unsigned serial_of(int unsigned y, int unsigned m, int unsigned d);
			int unsigned p, n, i;
			p = y - 1;
			n = 365 * p + p / 4 - p / 100 + p / 400;
			for (i = 1; i < m; i++)
				n += days_in_month(is_leap(y), i);
			return n + d - 1;
		endfunction

		function void serial_to_date(input int unsigned n, output int unsigned y,
				output int unsigned m, output int unsigned d);
			int unsigned q400, q100, q4, q1, r;
			bit lp;
			q400 = n / 146097;
			r    = n % 146097;
			q100 = r / 36524;
			if (q100 > 3)
				q100 = 3;
			r  = r - q100 * 36524;
			q4 = r / 1461;
			r  = r - q4 * 1461;
			q1 = r / 365;
			if (q1 > 3)
				q1 = 3;
			r  = r - q1 * 365;
			y  = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
			lp = is_leap(y);
			m  = 1;
			while (m < 12 && r >= days_in_month(lp, m)) begin
				r = r - days_in_month(lp, m);
				m++;
			end
			d = r + 1;
		endfunction

		function gdu_rsp_t predict(gdu_req_t r);
			gdu_rsp_t    o;
			int unsigned s, top, stride, lo, hi, ny, nm, nd;
			o              = '0;
			o.result_year  = r.year;
			o.result_month = r.month;
			o.result_day   = r.day;
			o.status       = ST_OK;
			if (r.operation <= OP_WEEKDAY && !date_ok(r.year, r.month, r.day)) begin
				o.status = ST_INVALID;
			end else begin
				case (r.operation)
					OP_NEXT, OP_PREV, OP_ADD, OP_SUB: begin
						s      = serial_of(r.year, r.month, r.day);
						top    = serial_of(year_limit, 12, 31);
						stride = (r.operation == OP_NEXT || r.operation == OP_PREV) ?
							1 : r.day_count;
						if (r.operation == OP_NEXT || r.operation == OP_ADD) begin
							if (s + stride > top)
								o.status = ST_RANGE;
							else
								s = s + stride;
						end else if (stride > s) begin
							o.status = ST_RANGE;
						end else begin
							s = s - stride;
						end
						if (o.status == ST_OK) begin
							serial_to_date(s, ny, nm, nd);
							o.result_year  = 14'(ny);
							o.result_month = 4'(nm);
							o.result_day   = 5'(nd);
						end
					end
					OP_BETWEEN: begin
						if (!date_ok(r.later_year, r.later_month, r.later_day)) begin
							o.status = ST_INVALID;
						end else begin
							lo = serial_of(r.year, r.month, r.day);
							hi = serial_of(r.later_year, r.later_month, r.later_day);
							if (lo > hi)
								o.status = ST_ORDER;
							else
								o.days_apart = 22'((hi - lo > APART_MAX) ? APART_MAX : hi - lo);
						end
					end
					// 0001-01-01 was a Monday
					OP_WEEKDAY: o.weekday = 3'((serial_of(r.year, r.month, r.day) + 1) % 7);
					default: ;
				endcase
			end
			return o;
		endfunction

		function void note_request(gdu_req_t r);
			expected_rsp.push_back(predict(r));
		endfunction

		function void check_response(gdu_rsp_t got);
			gdu_rsp_t want;
			if (expected_rsp.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result with nothing pending: %0d-%0d-%0d apart %0d wd %0d st %0d",
						got.result_year, got.result_month, got.result_day,
						got.days_apart, got.weekday, got.status);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.result_year !== want.result_year || got.result_month !== want.result_month ||
					got.result_day !== want.result_day || got.days_apart !== want.days_apart ||
					got.weekday !== want.weekday || got.status !== want.status) begin
				failures++;
				if (failures <= 10)
					$display("result %0d: expected %0d-%0d-%0d apart %0d wd %0d st %0d, got %0d-%0d-%0d apart %0d wd %0d st %0d",
						results_seen, want.result_year, want.result_month, want.result_day,
						want.days_apart, want.weekday, want.status,
						got.result_year, got.result_month, got.result_day,
						got.days_apart, got.weekday, got.status);
			end
			results_seen++;
		endfunction

		function int unsigned outstanding();
			return expected_rsp.size();
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        req_valid    = 1'b0;
	logic        req_stall;
	gdu_req_t    req          = '0;
	logic        rsp_valid;
	logic        rsp_stall    = 1'b0;
	gdu_rsp_t    rsp;
	bit          hold_off_req = 1'b0;
	int unsigned quiet_cycles = 0;

	calendar_scoreboard sb;

	gregorian_date_unit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	function automatic gdu_req_t mk(input logic [2:0] op, input int unsigned y,
			input int unsigned m, input int unsigned d, input int unsigned cnt,
			input int unsigned ly, input int unsigned lm, input int unsigned ld);
		gdu_req_t b;
		b.operation   = op;
		b.year        = 14'(y);
		b.month       = 4'(m);
		b.day         = 5'(d);
		b.day_count   = 22'(cnt);
		b.later_year  = 14'(ly);
		b.later_month = 4'(lm);
		b.later_day   = 5'(ld);
		return b;
	endfunction

	task automatic send_beat(input gdu_req_t b);
		req       <= b;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(b);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// receiver: segments of random stall density, plus one long hold-off on request
	initial begin : rsp_side
		int unsigned seg_len, stall_pct;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			seg_len = $urandom_range(4, 60);
			case ($urandom_range(0, 3))
				0:       stall_pct = 0;
				1:       stall_pct = 25;
				2:       stall_pct = 50;
				default: stall_pct = 85;
			endcase
			repeat (seg_len) begin
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		gdu_req_t    plan[$];
		gdu_req_t    beat;
		int unsigned idx, burst_left, sel, y, m, d, ly, lm, ld, s, top, lim_day, k;
		bit          good;

		sb = new(YEAR_LIMIT);

		plan.push_back(mk(OP_NEXT, 2024, 2, 28, 0, 0, 0, 0));
		plan.push_back(mk(OP_NEXT, 2023, 2, 28, 0, 0, 0, 0));
		plan.push_back(mk(OP_NEXT, 1900, 2, 28, 0, 0, 0, 0));
		plan.push_back(mk(OP_NEXT, 2000, 2, 28, 0, 0, 0, 0));
		plan.push_back(mk(OP_NEXT, YEAR_LIMIT, 12, 31, 0, 0, 0, 0));
		plan.push_back(mk(OP_PREV, 1, 1, 1, 0, 0, 0, 0));
		plan.push_back(mk(OP_PREV, 2024, 3, 1, 0, 0, 0, 0));
		plan.push_back(mk(OP_ADD, 2023, 6, 15, 0, 0, 0, 0));
		plan.push_back(mk(OP_SUB, 2023, 6, 15, 0, 16383, 15, 31));
		plan.push_back(mk(OP_ADD, 2000, 1, 1, 36524, 0, 0, 0));
		plan.push_back(mk(OP_SUB, 1, 1, 5, 10, 0, 0, 0));
		plan.push_back(mk(OP_ADD, YEAR_LIMIT, 12, 25, 10, 0, 0, 0));
		plan.push_back(mk(OP_ADD, YEAR_LIMIT, 12, 21, 10, 0, 0, 0));
		plan.push_back(mk(OP_BETWEEN, 2024, 1, 1, 0, 2024, 12, 31));
		plan.push_back(mk(OP_BETWEEN, 2024, 5, 17, 0, 2024, 5, 17));
		plan.push_back(mk(OP_BETWEEN, 2024, 3, 1, 0, 2024, 2, 1));
		plan.push_back(mk(OP_BETWEEN, 2023, 1, 1, 0, 2023, 2, 29));
		plan.push_back(mk(OP_BETWEEN, 2000, 1, 1, 0, 2100, 1, 1));
		plan.push_back(mk(OP_WEEKDAY, 2024, 1, 1, COUNT_ONES, 0, 0, 0));
		plan.push_back(mk(OP_WEEKDAY, 1, 1, 1, 0, 0, 0, 0));
		plan.push_back(mk(OP_WEEKDAY, YEAR_LIMIT, 12, 31, 0, 0, 0, 0));
		plan.push_back(mk(OP_NEXT, 0, 1, 1, 0, 0, 0, 0));
		plan.push_back(mk(OP_ADD, 2023, 13, 1, 5, 0, 0, 0));
		plan.push_back(mk(OP_PREV, 2023, 4, 31, 0, 0, 0, 0));
		plan.push_back(mk(OP_WEEKDAY, 16383, 15, 31, 0, 0, 0, 0));
		plan.push_back(mk(OP_SPARE_A, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_SPARE_B, 16383, 15, 31, COUNT_ONES, 16383, 15, 31));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = $urandom_range(1, 40);
		for (idx = 0; idx < ITEM_TOTAL; idx++) begin
			if (idx < plan.size()) begin
				beat = plan[idx];
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 4)
					beat.operation = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
				else
					beat.operation = 3'($urandom_range(0, 5));

				sel = $urandom_range(0, 99);
				if (sel < 8) begin
					y = $urandom_range(0, 16383);
					m = $urandom_range(0, 15);
					d = $urandom_range(0, 31);
				end else begin
					if (sel < 22) begin
						// near either end of the year range: early January of years 1 and 2, late December of the last two years
						y = $urandom_range(0, 1) ? $urandom_range(1, 2) :
							$urandom_range(YEAR_LIMIT - 1, YEAR_LIMIT);
						m = (y <= 2) ? 1 : 12;
					end else if (sel < 37) begin
						// century years around the leap exceptions, near month end
						y = $urandom_range(16, 24) * 100 +
							($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
						m = $urandom_range(2, 3);
					end else begin
						y = $urandom_range(1, YEAR_LIMIT);
						m = $urandom_range(1, 12);
					end
					lim_day = sb.days_in_month(sb.is_leap(y), m);
					if (sel < 12)
						d = (lim_day < 31 && $urandom_range(0, 1)) ?
							$urandom_range(lim_day + 1, 31) : 0;
					else if (sel < 22)
						d = (m == 1) ? $urandom_range(1, 5) : $urandom_range(25, 31);
					else if (sel < 37)
						d = lim_day - $urandom_range(0, 1);
					else
						d = $urandom_range(1, lim_day);
				end
				good = sb.date_ok(y, m, d);

				if (beat.operation == OP_ADD || beat.operation == OP_SUB) begin
					sel = $urandom_range(0, 99);
					if (sel < 85)
						beat.day_count = 22'($urandom_range(0, 40));
					else if (sel < 97)
						beat.day_count = 22'($urandom_range(41, 1500));
					else
						beat.day_count = 22'($urandom_range(1501, 8000));
				end else begin
					beat.day_count = 22'($urandom());
				end

				ly = $urandom();
				lm = $urandom();
				ld = $urandom();
				if (beat.operation == OP_BETWEEN) begin
					sel = $urandom_range(0, 99);
					if (good && sel < 90) begin
						s   = sb.serial_of(y, m, d);
						top = sb.serial_of(YEAR_LIMIT, 12, 31);
						if (sel < 70) begin
							s = s + $urandom_range(0, 60);
						end else if (sel < 80) begin
							s = s + $urandom_range(61, 3000);
						end else begin
							k = $urandom_range(1, 400);
							s = (k > s) ? 0 : s - k;
						end
						if (s > top)
							s = top;
						sb.serial_to_date(s, ly, lm, ld);
					end else begin
						// keep the second date close so a walk stays short
						ly = y + $urandom_range(0, 1);
						lm = $urandom_range(0, 15);
						ld = $urandom_range(0, 31);
					end
				end

				beat.year        = 14'(y);
				beat.month       = 4'(m);
				beat.day         = 5'(d);
				beat.later_year  = 14'(ly);
				beat.later_month = 4'(lm);
				beat.later_day   = 5'(ld);
			end

			if (idx == plan.size() || idx == DRAIN_AT)
				wait_drained();
			if (idx == HOLD_AT)
				hold_off_req = 1'b1;

			if (burst_left == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end
			send_beat(beat);
			burst_left--;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[filelist.f]
sv/gdu_pkg.sv
sv/gdu_div.sv
sv/gdu_date.sv
sv/gregorian_date_unit_core.sv
test/testbench.sv
